// ===== src/fom_pkg.sv =====
// Shared types, widths and the quarter-wave sine table for the field-oriented mixer.
// No dependencies; every other file imports this package.
`default_nettype none
package fom_pkg;

  // Curved axis, Q8.15 signed
  localparam int C_BITS = 24;
  // Sine and cosine, Q15 signed (+1.0 = 32768)
  localparam int TRIG_BITS = 18;
  // Mixed wheel value, Q10.15 signed
  localparam int W_BITS = 26;
  // Rotation products
  localparam int P_BITS = C_BITS + TRIG_BITS;

  // floor(x*|x|*32768/127) = 258*n + floor(2n/127), with 2n biased by 127*259
  localparam int CURVE_MUL = 258;
  localparam int CURVE_BIAS = 32893;
  localparam int CURVE_OFS = 259;
  localparam int DIV127_K = 66052;
  localparam int DIV127_SHIFT = 23;
  localparam int DIV127 = 127;

  typedef struct packed {
    logic signed [7:0] forward_stick;
    logic signed [7:0] turn_stick;
    logic signed [7:0] strafe_stick;
    logic [15:0]       heading;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] left_front_power;
    logic signed [7:0] left_back_power;
    logic signed [7:0] right_front_power;
    logic signed [7:0] right_back_power;
    logic              brake_request;
  } out_item_t;

  // Mixed wheels leaving the front end: lf, lb, rf, rb
  typedef struct packed {
    logic                    valid;
    logic [3:0][W_BITS-1:0]  w;
  } wheel_bus_t;

  // Scaled, floored wheel powers before saturation
  typedef struct packed {
    logic                    valid;
    logic [3:0][W_BITS-1:0]  v;
  } power_bus_t;

  // Quarter-wave sine, 16 steps of pi/32, Q15
  function automatic logic [16:0] qtab_base(input logic [4:0] idx);
    logic [16:0] r;
    case (idx)
      5'd0:    r = 17'd0;
      5'd1:    r = 17'd3212;
      5'd2:    r = 17'd6393;
      5'd3:    r = 17'd9512;
      5'd4:    r = 17'd12540;
      5'd5:    r = 17'd15447;
      5'd6:    r = 17'd18205;
      5'd7:    r = 17'd20788;
      5'd8:    r = 17'd23170;
      5'd9:    r = 17'd25330;
      5'd10:   r = 17'd27246;
      5'd11:   r = 17'd28899;
      5'd12:   r = 17'd30274;
      5'd13:   r = 17'd31357;
      5'd14:   r = 17'd32138;
      5'd15:   r = 17'd32610;
      default: r = 17'd32768;
    endcase
    return r;
  endfunction

  // Step to the next table entry; zero at the top of the quadrant
  function automatic logic [11:0] qtab_step(input logic [4:0] idx);
    logic [16:0] d;
    d = qtab_base(5'(idx + 5'd1)) - qtab_base(idx);
    return d[11:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/fom_front.sv =====
// Front end: stick curve, sine/cosine lookup, heading rotation and X-drive mix.
// Six register stages; depends on fom_pkg.
`default_nettype none
module fom_front
  import fom_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_item_t   in_item,
  output wheel_bus_t wheel_o
);

  localparam int FB = ANGLE_BITS - 6;
  localparam int QW = ANGLE_BITS - 2;
  localparam int XW = ANGLE_BITS - 1;
  localparam logic [XW-1:0] QUARTER = XW'(1) << QW;

  logic [5:0] vld_r;

  // ---- stage 1: curve numerators, phase split
  logic [ANGLE_BITS-1:0] phase;
  logic [1:0]            quad;
  logic [XW-1:0]         x_sin, x_cos, q_ext;
  logic signed [7:0]     axis [3];
  logic signed [15:0]    n_c [3];
  logic [15:0]           a_c [3];

  generate
    if (ANGLE_BITS >= 16) begin : g_phase_up
      assign phase = ANGLE_BITS'(in_item.heading) << (ANGLE_BITS - 16);
    end else begin : g_phase_dn
      assign phase = in_item.heading[15 -: ANGLE_BITS];
    end
  endgenerate

  assign quad  = phase[ANGLE_BITS-1 -: 2];
  assign q_ext = {1'b0, phase[QW-1:0]};
  assign x_sin = quad[0] ? QUARTER - q_ext : q_ext;
  assign x_cos = quad[0] ? q_ext : QUARTER - q_ext;

  assign axis[0] = in_item.forward_stick;
  assign axis[1] = in_item.turn_stick;
  assign axis[2] = in_item.strafe_stick;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [7:0]         ax;
      logic signed [16:0] prod;
      logic signed [17:0] biased;
      ax     = axis[k][7] ? 8'(-axis[k]) : 8'(axis[k]);
      prod   = axis[k] * $signed({1'b0, ax});
      n_c[k] = 16'(prod);
      biased = 18'(n_c[k]) * 18'sd2 + 18'sd32893;
      a_c[k] = biased[15:0];
    end
  end

  logic signed [15:0] n1_r [3];
  logic [15:0]        a1_r [3];
  logic [4:0]         sidx1_r, cidx1_r;
  logic [FB-1:0]      sfrac1_r, cfrac1_r;
  logic               sneg1_r, cneg1_r;

  always_ff @(posedge clk) begin
    n1_r     <= n_c;
    a1_r     <= a_c;
    sidx1_r  <= x_sin[XW-1:FB];
    cidx1_r  <= x_cos[XW-1:FB];
    sfrac1_r <= x_sin[FB-1:0];
    cfrac1_r <= x_cos[FB-1:0];
    sneg1_r  <= quad[1];
    cneg1_r  <= quad[1] ^ quad[0];
  end

  // ---- stage 2: reciprocal estimate of /127, interpolation products
  logic [9:0]         q02_r [3];
  logic signed [15:0] n2_r [3];
  logic [15:0]        a2_r [3];
  logic [16:0]        sbase2_r, cbase2_r;
  logic [11+FB:0]     sprod2_r, cprod2_r;
  logic               sneg2_r, cneg2_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      q02_r[k] <= 10'((33'(a1_r[k]) * 33'(DIV127_K)) >> DIV127_SHIFT);
    end
    n2_r     <= n1_r;
    a2_r     <= a1_r;
    sbase2_r <= qtab_base(sidx1_r);
    cbase2_r <= qtab_base(cidx1_r);
    sprod2_r <= (12 + FB)'(qtab_step(sidx1_r)) * (12 + FB)'(sfrac1_r);
    cprod2_r <= (12 + FB)'(qtab_step(cidx1_r)) * (12 + FB)'(cfrac1_r);
    sneg2_r  <= sneg1_r;
    cneg2_r  <= cneg1_r;
  end

  // ---- stage 3: correct quotient, finish curve; sign the trig values
  logic signed [C_BITS-1:0]    c_c [3];
  logic signed [TRIG_BITS-1:0] sn_c, cs_c;
  logic [16:0]                 smag, cmag;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [16:0]        rem;
      logic [9:0]         q;
      logic signed [25:0] cv;
      rem    = 17'(a2_r[k]) - 17'(q02_r[k]) * 17'(DIV127);
      q      = (rem >= 17'(DIV127)) ? 10'(q02_r[k] + 10'd1) : q02_r[k];
      cv     = 26'(n2_r[k]) * 26'sd258 + $signed(26'(q)) - 26'sd259;
      c_c[k] = C_BITS'(cv);
    end
    smag = sbase2_r + 17'(sprod2_r >> FB);
    cmag = cbase2_r + 17'(cprod2_r >> FB);
    sn_c = sneg2_r ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
    cs_c = cneg2_r ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
  end

  logic signed [C_BITS-1:0]    c3_r [3];
  logic signed [TRIG_BITS-1:0] sn3_r, cs3_r;

  always_ff @(posedge clk) begin
    c3_r  <= c_c;
    sn3_r <= sn_c;
    cs3_r <= cs_c;
  end

  // ---- stage 4: rotation products (f = 0, t = 1, s = 2)
  logic signed [P_BITS-1:0] sc4_r, fs4_r, fc4_r, ss4_r;
  logic signed [C_BITS-1:0] t4_r;

  always_ff @(posedge clk) begin
    sc4_r <= c3_r[2] * cs3_r;
    fs4_r <= c3_r[0] * sn3_r;
    fc4_r <= c3_r[0] * cs3_r;
    ss4_r <= c3_r[2] * sn3_r;
    t4_r  <= c3_r[1];
  end

  // ---- stage 5: rotated forward and strafe, floored to Q15
  logic signed [P_BITS:0] fsum, ssum;
  logic signed [W_BITS-1:0] nf5_r, ns5_r, t5_r;

  assign fsum = (P_BITS + 1)'(sc4_r) + (P_BITS + 1)'(fs4_r);
  assign ssum = (P_BITS + 1)'(fc4_r) - (P_BITS + 1)'(ss4_r);

  always_ff @(posedge clk) begin
    nf5_r <= W_BITS'(fsum >>> 15);
    ns5_r <= W_BITS'(ssum >>> 15);
    t5_r  <= W_BITS'(t4_r);
  end

  // ---- stage 6: wheel mix
  logic signed [W_BITS-1:0] w6_r [4];

  always_ff @(posedge clk) begin
    w6_r[0] <= nf5_r + ns5_r + t5_r;
    w6_r[1] <= nf5_r - ns5_r + t5_r;
    w6_r[2] <= nf5_r - ns5_r - t5_r;
    w6_r[3] <= nf5_r + ns5_r - t5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_comb begin
    wheel_o.valid = vld_r[5];
    for (int k = 0; k < 4; k++) begin
      wheel_o.w[k] = w6_r[k];
    end
  end

endmodule
`default_nettype wire

// ===== src/fom_scale.sv =====
// Power scaling: true maximum of four, pipelined restoring divide of w*limit by max,
// floor and fallback selection. Depends on fom_pkg.
`default_nettype none
module fom_scale
  import fom_pkg::*;
#(
  parameter int POWER_LIMIT = 127
) (
  input  logic       clk,
  input  logic       rst_n,
  input  wheel_bus_t wheel_i,
  output power_bus_t power_o
);

  localparam int QB = $clog2(POWER_LIMIT + 1);
  localparam int MW = W_BITS - 1;
  localparam int AW = MW + QB;
  localparam int FBW = W_BITS - 15;
  localparam longint LIM_Q = longint'(POWER_LIMIT) * 32768;

  // ---- stage T1: magnitudes
  logic                     v1_r;
  logic signed [W_BITS-1:0] w1_r [4];
  logic [MW-1:0]            ab1_r [4];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      w1_r[k]  <= $signed(wheel_i.w[k]);
      ab1_r[k] <= wheel_i.w[k][W_BITS-1] ? MW'(-$signed(wheel_i.w[k])) : MW'(wheel_i.w[k]);
    end
  end

  // ---- stage 0 of the divide: max, numerators, fallback
  logic [MW-1:0] m01, m23, m_c;

  always_comb begin
    m01 = (ab1_r[0] > ab1_r[1]) ? ab1_r[0] : ab1_r[1];
    m23 = (ab1_r[2] > ab1_r[3]) ? ab1_r[2] : ab1_r[3];
    m_c = (m01 > m23) ? m01 : m23;
  end

  logic [QB:0]           vld_r;
  logic [MW-1:0]         m_p   [QB+1];
  logic                  big_p [QB+1];
  logic [3:0]            neg_p [QB+1];
  logic signed [FBW-1:0] fb_p  [QB+1][4];
  logic [AW-1:0]         rem_p [QB+1][4];
  logic [QB-1:0]         quo_p [QB+1][4];

  logic                  ge_c   [QB][4];
  logic [AW-1:0]         diff_c [QB][4];

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      for (int k = 0; k < 4; k++) begin
        logic [AW-1:0] dv;
        dv           = AW'(m_p[j]) << (QB - 1 - j);
        ge_c[j][k]   = rem_p[j][k] >= dv;
        diff_c[j][k] = rem_p[j][k] - dv;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_p[0]   <= m_c;
    big_p[0] <= 33'(m_c) > 33'(LIM_Q);
    for (int k = 0; k < 4; k++) begin
      neg_p[0][k]  <= w1_r[k][W_BITS-1];
      fb_p[0][k]   <= FBW'(w1_r[k] >>> 15);
      rem_p[0][k]  <= AW'(ab1_r[k]) * AW'(POWER_LIMIT);
      quo_p[0][k]  <= '0;
    end
    // One quotient bit per stage, most significant first
    for (int j = 0; j < QB; j++) begin
      m_p[j+1]   <= m_p[j];
      big_p[j+1] <= big_p[j];
      neg_p[j+1] <= neg_p[j];
      for (int k = 0; k < 4; k++) begin
        fb_p[j+1][k]  <= fb_p[j][k];
        rem_p[j+1][k] <= ge_c[j][k] ? diff_c[j][k] : rem_p[j][k];
        quo_p[j+1][k] <= QB'({quo_p[j][k], ge_c[j][k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vld_r <= '0;
    end else begin
      v1_r  <= wheel_i.valid;
      vld_r <= (QB + 1)'({vld_r, v1_r});
    end
  end

  // Floor of signed quotient (negative, inexact: magnitude up), else the fallback
  always_comb begin
    power_o.valid = vld_r[QB];
    for (int k = 0; k < 4; k++) begin
      logic signed [W_BITS-1:0] qe;
      qe = $signed(W_BITS'(quo_p[QB][k]));
      if (neg_p[QB][k] && (rem_p[QB][k] != '0)) begin
        qe = qe + W_BITS'(1);
      end
      if (big_p[QB]) begin
        power_o.v[k] = neg_p[QB][k] ? -qe : qe;
      end else begin
        power_o.v[k] = W_BITS'(fb_p[QB][k]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/field_oriented_xdrive_mixer_top.sv =====
// Top level of the field-oriented X-drive mixer: front end, scaler, output stage.
// Depends on fom_pkg, fom_front and fom_scale.
//
// Usage:
//   Drive in_item (three signed stick axes and a 16-bit heading) and raise start.
//   A transfer happens at each rising edge where start is high and busy is low.
//   busy is high only while rst_n is low and for the first cycle after it; a new
//   item may then enter on every clock.
//   Each item produces one result: four floored wheel powers and brake_request.
//   The result sits on out_item for exactly one cycle with out_valid high and is
//   taken at the edge closing that cycle.
// Pipeline: six stages of curve, trig, rotation and mix; two of magnitude and
//   max; one restoring-divide stage per quotient bit; one output register.
// Throughput: one item per cycle, results in input order.
// Reset: synchronous, clears every valid bit; items in flight are dropped.
// The receiver cannot stall, so the pipeline never holds; nothing waits.
`default_nettype none
module field_oriented_xdrive_mixer_top
  import fom_pkg::*;
#(
  parameter int POWER_LIMIT = 127,
  parameter int ANGLE_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int QB  = $clog2(POWER_LIMIT + 1);
  localparam int LAT = 9 + QB;

  logic       busy_r;
  logic       accept;
  wheel_bus_t wheels;
  power_bus_t powers;

  // Hold off transfers during reset and the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  fom_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(accept),
    .in_item (in_item),
    .wheel_o (wheels)
  );

  fom_scale #(
    .POWER_LIMIT(POWER_LIMIT)
  ) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .wheel_i(wheels),
    .power_o(powers)
  );

  // Clamp to the 8-bit field, then flag brake when all four land on zero
  logic signed [7:0] sat_c [4];
  out_item_t         out_nxt;
  out_item_t         out_item_r;
  logic              out_valid_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic signed [W_BITS-1:0] v;
      v = $signed(powers.v[k]);
      if (v > W_BITS'(127)) begin
        sat_c[k] = 8'sd127;
      end else if (v < -W_BITS'(128)) begin
        sat_c[k] = -8'sd128;
      end else begin
        sat_c[k] = v[7:0];
      end
    end
    out_nxt.left_front_power  = sat_c[0];
    out_nxt.left_back_power   = sat_c[1];
    out_nxt.right_front_power = sat_c[2];
    out_nxt.right_back_power  = sat_c[3];
    out_nxt.brake_request     = (sat_c[0] == 8'sd0) && (sat_c[1] == 8'sd0) &&
                                (sat_c[2] == 8'sd0) && (sat_c[3] == 8'sd0);
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= powers.valid;
    end
  end

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

`ifndef SYNTH
  localparam int PL_SAT = (POWER_LIMIT < 127) ? POWER_LIMIT : 127;
  localparam int PL_LO  = (POWER_LIMIT < 128) ? POWER_LIMIT : 128;

  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("transfer did not produce a result on time");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching transfer");

  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_item.left_front_power) >= -PL_LO) &&
                  ($signed(out_item.left_back_power) >= -PL_LO) &&
                  ($signed(out_item.right_front_power) >= -PL_LO) &&
                  ($signed(out_item.right_back_power) >= -PL_LO) &&
                  ($signed(out_item.left_front_power) <= PL_SAT) &&
                  ($signed(out_item.left_back_power) <= PL_SAT) &&
                  ($signed(out_item.right_front_power) <= PL_SAT) &&
                  ($signed(out_item.right_back_power) <= PL_SAT))
    else $error("wheel power beyond the power limit");
`endif

endmodule
`default_nettype wire
